>>> sv/irup_pkg.sv
package irup_pkg;

  localparam int MAX_NAME_DEF = 10;
  localparam int LEN_W = 4;

  // field phases
  localparam logic [2:0] PH_REMOTE = 3'd0;
  localparam logic [2:0] PH_LOCAL  = 3'd1;
  localparam logic [2:0] PH_KEY    = 3'd2;
  localparam logic [2:0] PH_PRE    = 3'd3;
  localparam logic [2:0] PH_COPY   = 3'd4;
  localparam logic [2:0] PH_REJECT = 3'd5;

  // number recognizer states
  localparam logic [1:0] NUM_WS   = 2'd0;
  localparam logic [1:0] NUM_SIGN = 2'd1;
  localparam logic [1:0] NUM_DIG  = 2'd2;
  localparam logic [1:0] NUM_DONE = 2'd3;

  localparam logic [2:0] KEY_LEN = 3'd6;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BRACK = 8'h5B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_U     = 8'h55;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       name_char;
    logic             verdict;
    logic [LEN_W-1:0] name_length;
    logic             out_last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] st;
    logic       nz;
  } num_t;

  function automatic logic [7:0] key_char(input logic [2:0] p);
    logic [7:0] k;
    case (p)
      3'd0:    k = 8'h55; // U
      3'd1:    k = 8'h53; // S
      3'd2:    k = 8'h45; // E
      3'd3:    k = 8'h52; // R
      3'd4:    k = 8'h49; // I
      3'd5:    k = 8'h44; // D
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // one byte through the atoi-style recognizer
  function automatic num_t num_feed(input num_t n, input logic [7:0] c);
    num_t r;
    r = n;
    case (n.st)
      NUM_WS: begin
        if (is_ws(c)) begin
          r.st = NUM_WS;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          r.st = NUM_SIGN;
        end else if (is_digit(c)) begin
          r.st = NUM_DIG;
          if (c != CH_ZERO) r.nz = 1'b1;
        end else begin
          r.st = NUM_DONE;
        end
      end
      NUM_SIGN, NUM_DIG: begin
        if (is_digit(c)) begin
          r.st = NUM_DIG;
          if (c != CH_ZERO) r.nz = 1'b1;
        end else begin
          r.st = NUM_DONE;
        end
      end
      default: r = n;
    endcase
    return r;
  endfunction

endpackage

>>> sv/ident_reply_username_parser_core.sv
// Flow: an accepted word is held in the input register; once the output queue has
// room for two results, its results are written there and offered from the queue head.
// Throughput: one input word per cycle while the queue has room; a last word that also
// yields a character pushes two results, and the 4-entry output queue drains them one per cycle while out_stall is low.
// Reset (rst_n low, synchronous): parser state returns to the start of a reply,
// input register and output queue are emptied.
module ident_reply_username_parser_core
  import irup_pkg::*;
#(
  parameter int MAX_NAME = MAX_NAME_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_NAME);

  // input register
  logic     in_v_r, in_v_nxt;
  in_word_t in_r;

  // parser state
  logic [2:0]       phase_r, phase_nxt;
  num_t             rem_r, rem_nxt;
  num_t             loc_r, loc_nxt;
  logic [2:0]       kprog_r, kprog_nxt;
  logic             kfound_r, kfound_nxt;
  logic             lead_r, lead_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             stop_r, stop_nxt;
  logic             ended_r, ended_nxt;

  // output queue
  out_word_t        q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic       room, adv, accept, pop;
  logic       emit_char;
  logic [1:0] n_push;
  out_word_t  res0, res1, verdict_w;
  logic [7:0] c;

  assign room   = count_r <= CNT_W'(DEPTH - 2);
  assign adv    = in_v_r && room;
  assign in_stall = in_v_r && !room;
  assign accept = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign out_word  = q_r[rd_ptr_r];
  assign pop    = out_valid && !out_stall;
  assign c      = in_r.in_byte;

  always_comb begin
    in_v_nxt = accept ? 1'b1 : (adv ? 1'b0 : in_v_r);
  end

  always_comb begin
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    loc_nxt    = loc_r;
    kprog_nxt  = kprog_r;
    kfound_nxt = kfound_r;
    lead_nxt   = lead_r;
    left_nxt   = left_r;
    stop_nxt   = stop_r;
    ended_nxt  = ended_r || (c == 8'h00);
    emit_char  = 1'b0;

    if (!ended_nxt) begin
      unique case (phase_r)
        PH_REMOTE: begin
          if (c == CH_COMMA) phase_nxt = PH_LOCAL;
          else if (c == CH_COLON) phase_nxt = PH_REJECT;
          else rem_nxt = num_feed(rem_r, c);
        end
        PH_LOCAL: begin
          if (c == CH_COLON) phase_nxt = PH_KEY;
          else loc_nxt = num_feed(loc_r, c);
        end
        PH_KEY: begin
          if (c == CH_COLON) begin
            phase_nxt = PH_PRE;
          end else if (!kfound_r) begin
            if (kprog_r < KEY_LEN && c == key_char(kprog_r)) begin
              kprog_nxt = kprog_r + 3'd1;
              if (kprog_nxt == KEY_LEN) kfound_nxt = 1'b1;
            end else begin
              kprog_nxt = (c == CH_U) ? 3'd1 : 3'd0;
            end
          end
        end
        PH_PRE: begin
          if (c == CH_COLON) begin
            phase_nxt = (rem_r.nz && loc_r.nz && kfound_r) ? PH_COPY : PH_REJECT;
          end
        end
        PH_COPY: begin
          if (!(lead_r && (c == CH_TILDE || c == CH_CARET))) begin
            lead_nxt = 1'b0;
            if (!stop_r && left_r != '0) begin
              if (c == CH_AT || c == CH_CR || c == CH_LF) begin
                stop_nxt = 1'b1;
              end else if (c != CH_SPACE && c != CH_COLON && c != CH_BRACK) begin
                emit_char = 1'b1;
                left_nxt  = left_r - LEN_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end

    // verdict from the updated state
    verdict_w.kind      = 1'b1;
    verdict_w.name_char = 8'h00;
    verdict_w.out_last  = 1'b1;
    if (phase_nxt == PH_COPY) begin
      verdict_w.verdict     = 1'b0;
      verdict_w.name_length = MAX_LEN - left_nxt;
    end else begin
      verdict_w.verdict     = 1'b1;
      verdict_w.name_length = '0;
    end

    if (in_r.in_last) begin
      phase_nxt  = PH_REMOTE;
      rem_nxt    = '{st: NUM_WS, nz: 1'b0};
      loc_nxt    = '{st: NUM_WS, nz: 1'b0};
      kprog_nxt  = '0;
      kfound_nxt = 1'b0;
      lead_nxt   = 1'b1;
      left_nxt   = MAX_LEN;
      stop_nxt   = 1'b0;
      ended_nxt  = 1'b0;
    end

    res0.kind        = 1'b0;
    res0.name_char   = c;
    res0.verdict     = 1'b0;
    res0.name_length = '0;
    res0.out_last    = 1'b0;
    res1 = verdict_w;
    if (!emit_char) res0 = verdict_w;
    n_push = 2'(emit_char) + 2'(in_r.in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      phase_r  <= PH_REMOTE;
      rem_r    <= '{st: NUM_WS, nz: 1'b0};
      loc_r    <= '{st: NUM_WS, nz: 1'b0};
      kprog_r  <= '0;
      kfound_r <= 1'b0;
      lead_r   <= 1'b1;
      left_r   <= MAX_LEN;
      stop_r   <= 1'b0;
      ended_r  <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (adv) begin
        phase_r  <= phase_nxt;
        rem_r    <= rem_nxt;
        loc_r    <= loc_nxt;
        kprog_r  <= kprog_nxt;
        kfound_r <= kfound_nxt;
        lead_r   <= lead_nxt;
        left_r   <= left_nxt;
        stop_r   <= stop_nxt;
        ended_r  <= ended_nxt;
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + (adv ? CNT_W'(n_push) : '0) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_word;
    if (adv && n_push != 2'd0) q_r[wr_ptr_r] <= res0;
    if (adv && n_push == 2'd2) q_r[wr_ptr_r + PTR_W'(1)] <= res1;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("output queue count beyond depth");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_r.in_last) |=> (phase_r == PH_REMOTE && left_r == MAX_LEN && lead_r))
    else $error("parser state not cleared after reply end");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= MAX_LEN)
    else $error("character budget above maximum");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("stall without a held word");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.kind == out_word.out_last))
    else $error("verdict and last flag disagree");

endmodule

>>> tb/sv/ident_reply_username_parser_core_tb.sv
module ident_reply_username_parser_core_tb;
  import irup_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_BYTES   = 1100;
  localparam int          LONG_HOLD      = 400;
  localparam logic [47:0] USERID_TXT     = "USERID";
  localparam logic [7:0]  CH_NUL         = 8'h00;
  localparam logic [7:0]  WS_LO          = 8'h09;
  localparam logic [7:0]  WS_HI          = 8'h0D;

  // receiver stall patterns
  localparam int RX_FREE   = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;
  localparam int RX_PERIOD = 3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  ident_reply_username_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // parser state mirror
  logic [2:0] phase;
  logic [1:0] rem_st;
  logic       rem_nz;
  logic [1:0] loc_st;
  logic       loc_nz;
  logic [2:0] key_pos;
  logic       key_hit;
  logic       lead_skip;
  logic [3:0] room;
  logic       halted;
  logic       str_done;

  out_word_t  parse_results_q[$];
  logic [7:0] reply_bytes[$];

  int errors;
  int bytes_sent;
  int replies_seen;
  int names_found;
  int replies_bad;
  int chars_seen;
  int burst_left;
  int rx_hold_left;
  int rx_mode;
  int rx_cycle;
  int idle_cycles;

  task automatic clear_parser();
    phase     = PH_REMOTE;
    rem_st    = NUM_WS;
    rem_nz    = 1'b0;
    loc_st    = NUM_WS;
    loc_nz    = 1'b0;
    key_pos   = '0;
    key_hit   = 1'b0;
    lead_skip = 1'b1;
    room      = LEN_W'(MAX_NAME_DEF);
    halted    = 1'b0;
    str_done  = 1'b0;
  endtask

  task automatic step_number(inout logic [1:0] st, inout logic nz, input logic [7:0] c);
    logic dig;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    case (st)
      NUM_WS: begin
        if (c == CH_SPACE || (c >= WS_LO && c <= WS_HI)) begin
          st = NUM_WS;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          st = NUM_SIGN;
        end else if (dig) begin
          st = NUM_DIG;
          if (c != CH_ZERO) nz = 1'b1;
        end else begin
          st = NUM_DONE;
        end
      end
      NUM_SIGN, NUM_DIG: begin
        if (dig) begin
          st = NUM_DIG;
          if (c != CH_ZERO) nz = 1'b1;
        end else begin
          st = NUM_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic step_keyword(input logic [7:0] c);
    if (!key_hit) begin
      if (key_pos < KEY_LEN && c == USERID_TXT[8*(5-key_pos) +: 8]) begin
        key_pos = key_pos + 3'd1;
        if (key_pos == KEY_LEN) key_hit = 1'b1;
      end else begin
        key_pos = (c == CH_U) ? 3'd1 : 3'd0;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic l);
    out_word_t w;
    if (c == CH_NUL) str_done = 1'b1;
    if (!str_done) begin
      case (phase)
        PH_REMOTE: begin
          if (c == CH_COMMA) phase = PH_LOCAL;
          else if (c == CH_COLON) phase = PH_REJECT;
          else step_number(rem_st, rem_nz, c);
        end
        PH_LOCAL: begin
          if (c == CH_COLON) phase = PH_KEY;
          else step_number(loc_st, loc_nz, c);
        end
        PH_KEY: begin
          if (c == CH_COLON) phase = PH_PRE;
          else step_keyword(c);
        end
        PH_PRE: begin
          if (c == CH_COLON) phase = (rem_nz && loc_nz && key_hit) ? PH_COPY : PH_REJECT;
        end
        PH_COPY: begin
          if (!(lead_skip && (c == CH_TILDE || c == CH_CARET))) begin
            lead_skip = 1'b0;
            if (!halted && room != 0) begin
              if (c == CH_AT || c == CH_CR || c == CH_LF) begin
                halted = 1'b1;
              end else if (c != CH_SPACE && c != CH_COLON && c != CH_BRACK) begin
                w = '0;
                w.name_char = c;
                parse_results_q.push_back(w);
                room = room - 4'd1;
                chars_seen++;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (l) begin
      w = '0;
      w.kind = 1'b1;
      w.out_last = 1'b1;
      if (phase == PH_COPY) begin
        w.name_length = LEN_W'(MAX_NAME_DEF) - room;
        names_found++;
      end else begin
        w.verdict = 1'b1;
        replies_bad++;
      end
      parse_results_q.push_back(w);
      replies_seen++;
      clear_parser();
    end
  endtask

  // predict on accepted input words, check accepted output words
  out_word_t want;
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) parse_byte(in_word.in_byte, in_word.in_last);
    if (rst_n && out_valid && !out_stall) begin
      if (parse_results_q.size() == 0) begin
        $error("unexpected result word %h", out_word);
        errors++;
      end else begin
        want = parse_results_q.pop_front();
        if (out_word.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_word.kind);
          errors++;
        end
        if (out_word.name_char !== want.name_char) begin
          $error("name_char: expected %h, got %h", want.name_char, out_word.name_char);
          errors++;
        end
        if (out_word.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_word.verdict);
          errors++;
        end
        if (out_word.name_length !== want.name_length) begin
          $error("name_length: expected %0d, got %0d", want.name_length, out_word.name_length);
          errors++;
        end
        if (out_word.out_last !== want.out_last) begin
          $error("out_last: expected %0d, got %0d", want.out_last, out_word.out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ident_reply_username_parser_core_tb: FAIL");
      $finish;
    end
  end

  // receiver: long hold when requested, else one of the stall patterns, re-chosen at random
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(RX_FREE, RX_PERIOD);
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((rx_cycle % 8) >= 5);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    in_word_t nxt;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    nxt.in_byte = b;
    nxt.in_last = l;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= nxt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic tx_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    @(negedge clk);
    while (parse_results_q.size() != 0) @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    reply_bytes.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
  endtask

  task automatic send_reply();
    for (int i = 0; i < reply_bytes.size(); i++) send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    reply_bytes.delete();
  endtask

  task automatic add_spaces();
    repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
  endtask

  task automatic add_number();
    repeat ($urandom_range(0, 2)) begin
      add_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(WS_LO, WS_HI)) : CH_SPACE);
    end
    if ($urandom_range(0, 3) == 0) add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3)) begin
      add_byte(($urandom_range(0, 5) == 0) ? CH_ZERO : 8'($urandom_range(CH_ZERO + 1, CH_NINE)));
    end
    if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(8'h21, 8'h7E)));
    add_spaces();
  endtask

  function automatic logic [7:0] name_byte();
    int k;
    k = $urandom_range(0, 39);
    if (k == 0) return $urandom_range(0, 1) ? CH_AT : ($urandom_range(0, 1) ? CH_CR : CH_LF);
    if (k < 4) return ($urandom_range(0, 2) == 0) ? CH_SPACE : ($urandom_range(0, 1) ? CH_COLON : CH_BRACK);
    if (k < 8) return 8'($urandom_range(8'h80, 8'hFF));
    if (k < 10) return $urandom_range(0, 1) ? CH_TILDE : CH_CARET;
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic build_reply();
    int k;
    reply_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_number();
      k = $urandom_range(0, 19);
      if (k == 1) add_byte(CH_COLON);
      else if (k != 0) add_byte(CH_COMMA);
      add_number();
      if ($urandom_range(0, 19) != 0) add_byte(CH_COLON);
      add_spaces();
      case ($urandom_range(0, 9))
        0:       add_text("USERXD");
        1:       add_text("UUSERID");
        2:       add_text("ERROR");
        3:       add_text("userid");
        default: add_text("USERID");
      endcase
      add_spaces();
      if ($urandom_range(0, 19) != 0) add_byte(CH_COLON);
      add_text($urandom_range(0, 1) ? "UNIX" : "OTHER");
      if ($urandom_range(0, 19) != 0) add_byte(CH_COLON);
      repeat ($urandom_range(0, 3)) add_byte($urandom_range(0, 1) ? CH_TILDE : CH_CARET);
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8)) begin
        add_byte(name_byte());
      end
      if ($urandom_range(0, 3) == 0) add_text("@host");
      if ($urandom_range(0, 3) == 0) add_text("\r\n");
    end
    // cut the string short now and then
    if ($urandom_range(0, 11) == 0) reply_bytes[$urandom_range(0, reply_bytes.size() - 1)] = CH_NUL;
  endtask

  task automatic test_directed();
    add_text("6193, 23 : USERID : UNIX :stjohns");
    send_reply();
    add_text("1,1:USERID::~^~ab cd[e:f@x");
    send_reply();
    add_text("+5,-7:xUSERIDx:OS:abcdefghijklmnop");
    send_reply();
    add_text("0,3:USERID:OS:abc");
    send_reply();
    add_text("12:USERID:X:a");
    send_reply();
    add_text("1,2 USERID");
    send_reply();
    add_text("1,1:USERUSERID:X:ab");
    add_byte(CH_NUL);
    add_text("cd");
    send_reply();
    add_text("9,9:USERID:X:");
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(8'hC3);
    send_reply();
    add_text("1,1:USERID:X:a\r\nb");
    send_reply();
    add_byte(CH_NUL);
    send_reply();
    add_byte(8'hFF);
    send_reply();
  endtask

  task automatic test_noise_bytes();
    repeat (150) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_output_hold();
    rx_hold_left = LONG_HOLD;
    repeat (4) begin
      build_reply();
      send_reply();
    end
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      build_reply();
      send_reply();
    end
    tx_idle();
    wait_results();
    repeat (4) @(negedge clk);
    add_text("42,7:USERID:UNIX:^pause");
    send_reply();
  endtask

  task automatic test_random_replies();
    int stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      build_reply();
      send_reply();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    errors       = 0;
    bytes_sent   = 0;
    replies_seen = 0;
    names_found  = 0;
    replies_bad  = 0;
    chars_seen   = 0;
    burst_left   = 0;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_noise_bytes();
    test_output_hold();
    test_sender_pause();
    test_random_replies();

    tx_idle();
    wait_results();
    repeat (10) @(posedge clk);
    $display("covered %0d reply bytes in %0d replies: %0d names found, %0d rejected,",
             bytes_sent, replies_seen, names_found, replies_bad);
    $display("%0d name characters, with sender bursts and receiver stalls", chars_seen);
    if (errors == 0) begin
      $display("ident_reply_username_parser_core_tb: PASS");
    end else begin
      $display("ident_reply_username_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule
